// File: hdl/tapc_pkg.sv
// Shared types and constants for the tilt actuator proportional controller.
// Holds the command and register codes, the state, item and result structs,
// and the reciprocal table used by the target map. No dependencies.
package tapc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_SET_TARGET = 2'd1,
        CMD_MANUAL     = 2'd2
    } tapc_cmd_t;

    typedef enum logic [2:0] {
        REG_MIN_DRIVE      = 3'd0,
        REG_MAX_DRIVE      = 3'd1,
        REG_DEADBAND       = 3'd2,
        REG_GAIN_Q4        = 3'd3,
        REG_POT_LOW_LIMIT  = 3'd4,
        REG_POT_HIGH_LIMIT = 3'd5,
        REG_JOY_DEADZONE   = 3'd6
    } tapc_reg_idx_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 48;

    // Register reset values.
    localparam logic [7:0] RST_MIN_DRIVE      = 8'd60;
    localparam logic [7:0] RST_MAX_DRIVE      = 8'd250;
    localparam logic [9:0] RST_DEADBAND       = 10'd10;
    localparam logic [9:0] RST_GAIN_Q4        = 10'd96;
    localparam logic [9:0] RST_POT_LOW_LIMIT  = 10'd215;
    localparam logic [9:0] RST_POT_HIGH_LIMIT = 10'd550;
    localparam logic [7:0] RST_JOY_DEADZONE   = 8'd40;

    // Target code meaning that no target has been set yet (-1).
    localparam logic signed [10:0] TARGET_NONE = -11'sd1;

    // Allowed target percentage window.
    localparam logic [6:0] PCT_LOW  = 7'd25;
    localparam logic [6:0] PCT_HIGH = 7'd69;
    localparam int PCT_SPAN = int'(PCT_HIGH) - int'(PCT_LOW) + 1;
    localparam int PCT_IDX_W = $clog2(PCT_SPAN);

    // Division by 100 as a multiply by ceil(2^23 / 100) and a shift. The
    // error term stays below one unit for every product of a clamped
    // percentage and a 10-bit span, so the quotient is exact.
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_K     = 83887;
    localparam int RECIP_W     = 23;

    typedef logic [RECIP_W-1:0] recip_table_t [PCT_SPAN];

    function automatic recip_table_t build_recip_table();
        recip_table_t tab;
        for (int i = 0; i < PCT_SPAN; i++) begin
            tab[i] = RECIP_W'((int'(PCT_LOW) + i) * RECIP_K);
        end
        return tab;
    endfunction

    // Entry i holds (25 + i) * RECIP_K, so one multiply covers pct / 100.
    localparam recip_table_t RECIP_TABLE = build_recip_table();

    typedef struct packed {
        logic [7:0] min_drive;
        logic [7:0] max_drive;
        logic [9:0] deadband;
        logic [9:0] gain_q4;
        logic [9:0] pot_low_limit;
        logic [9:0] pot_high_limit;
        logic [7:0] joystick_deadzone;
    } tapc_cfg_t;

    typedef struct packed {
        logic              manual_mode;
        logic signed [10:0] target_pos;
        logic [9:0]        current_pos;
        logic signed [8:0] applied_speed;
    } tapc_state_t;

    typedef struct packed {
        tapc_cmd_t         command;
        logic [9:0]        pot_sample;
        logic [6:0]        target_percent;
        logic signed [9:0] joystick;
    } tapc_item_t;

    typedef struct packed {
        logic               dir_out;
        logic               dir_in;
        logic [7:0]         pwm_duty;
        logic signed [8:0]  drive_speed;
        logic               auto_mode;
        logic signed [10:0] target_raw;
        logic [9:0]         position_raw;
    } tapc_result_t;

endpackage

// File: hdl/tapc_step.sv
// Next-state and result logic for one controller command.
// Purely combinational; depends on tapc_pkg for the structs and tables.
module tapc_step
    import tapc_pkg::*;
(
    input  tapc_cfg_t    cfg,
    input  tapc_state_t  state,
    input  tapc_item_t   item,
    output tapc_state_t  state_next,
    output tapc_result_t result
);

    // Automatic drive.
    logic signed [11:0] err;
    logic        [11:0] err_mag;
    logic signed [22:0] err_prod;
    logic signed [22:0] err_prod_adj;
    logic signed [18:0] auto_raw;
    logic signed [18:0] auto_mn;
    logic signed [18:0] auto_mx;
    logic signed [18:0] auto_clamped;
    logic signed [8:0]  auto_drive;
    logic               auto_active;

    // Manual drive.
    logic signed [18:0] joy_prod;
    logic signed [18:0] joy_prod_adj;
    logic signed [10:0] man_raw;
    logic signed [10:0] man_mx;
    logic signed [10:0] man_clamped;
    logic        [10:0] man_mag;
    logic signed [8:0]  man_drive;

    // Target map.
    logic [6:0]           pct_clamped;
    logic [PCT_IDX_W-1:0] pct_idx;
    logic signed [10:0]   span;
    logic [9:0]           span_mag;
    logic [32:0]          map_prod;
    logic [9:0]           map_quot;
    logic signed [11:0]   map_signed;
    logic signed [11:0]   map_target;

    // Soft limits and final selection.
    logic signed [8:0] drive_cand;
    logic signed [8:0] drive_limited;
    logic              drive_update;
    logic signed [8:0] speed;

    always_comb begin
        err     = {state.target_pos[10], state.target_pos} - $signed({2'b00, item.pot_sample});
        err_mag = err[11] ? 12'(-err) : 12'(err);
        err_prod = 23'(err) * $signed(23'({1'b0, cfg.gain_q4}));
        // Truncate toward zero on the divide by 16.
        err_prod_adj = err_prod + (err_prod[22] ? 23'sd15 : 23'sd0);
        auto_raw = err_prod_adj[22:4];
        auto_mn  = $signed({11'b0, cfg.min_drive});
        auto_mx  = $signed({11'b0, cfg.max_drive});
        // Low bound is tested first, as the clamp defines it.
        if (auto_raw > 19'sd0) begin
            if (auto_raw < auto_mn) begin
                auto_clamped = auto_mn;
            end else if (auto_raw > auto_mx) begin
                auto_clamped = auto_mx;
            end else begin
                auto_clamped = auto_raw;
            end
        end else begin
            if (auto_raw < -auto_mx) begin
                auto_clamped = -auto_mx;
            end else if (auto_raw > -auto_mn) begin
                auto_clamped = -auto_mn;
            end else begin
                auto_clamped = auto_raw;
            end
        end
        auto_drive = (err_mag > {2'b00, cfg.deadband}) ? auto_clamped[8:0] : 9'sd0;
        auto_active = !state.manual_mode && (state.target_pos != TARGET_NONE);
    end

    always_comb begin
        joy_prod     = 19'(item.joystick) * $signed(19'({1'b0, cfg.max_drive}));
        joy_prod_adj = joy_prod + (joy_prod[18] ? 19'sd255 : 19'sd0);
        man_raw      = joy_prod_adj[18:8];
        man_mx       = $signed({3'b000, cfg.max_drive});
        if (man_raw > man_mx) begin
            man_clamped = man_mx;
        end else if (man_raw < -man_mx) begin
            man_clamped = -man_mx;
        end else begin
            man_clamped = man_raw;
        end
        man_mag   = man_clamped[10] ? 11'(-man_clamped) : 11'(man_clamped);
        man_drive = (man_mag < {3'b000, cfg.joystick_deadzone}) ? 9'sd0 : man_clamped[8:0];
    end

    always_comb begin
        if (item.target_percent < PCT_LOW) begin
            pct_clamped = PCT_LOW;
        end else if (item.target_percent > PCT_HIGH) begin
            pct_clamped = PCT_HIGH;
        end else begin
            pct_clamped = item.target_percent;
        end
        pct_idx    = PCT_IDX_W'(pct_clamped - PCT_LOW);
        span       = $signed({1'b0, cfg.pot_high_limit}) - $signed({1'b0, cfg.pot_low_limit});
        span_mag   = span[10] ? 10'(-span) : span[9:0];
        map_prod   = 33'(span_mag) * 33'(RECIP_TABLE[pct_idx]);
        map_quot   = 10'(map_prod >> RECIP_SHIFT);
        map_signed = span[10] ? -$signed({2'b00, map_quot}) : $signed({2'b00, map_quot});
        map_target = map_signed + $signed({2'b00, cfg.pot_low_limit});
    end

    always_comb begin
        drive_cand   = (item.command == CMD_MANUAL) ? man_drive : auto_drive;
        drive_limited = drive_cand;
        if (drive_cand > 9'sd0 && item.pot_sample >= cfg.pot_high_limit) begin
            drive_limited = 9'sd0;
        end
        if (drive_cand < 9'sd0 && item.pot_sample <= cfg.pot_low_limit) begin
            drive_limited = 9'sd0;
        end

        state_next   = state;
        drive_update = 1'b0;
        unique case (item.command)
            CMD_TICK: begin
                state_next.current_pos = item.pot_sample;
                drive_update = auto_active;
            end
            CMD_SET_TARGET: begin
                state_next.manual_mode = 1'b0;
                state_next.target_pos  = map_target[10:0];
            end
            CMD_MANUAL: begin
                state_next.manual_mode = 1'b1;
                state_next.current_pos = item.pot_sample;
                drive_update = 1'b1;
            end
            default: begin
                // Unused code: the state stays as it is.
            end
        endcase
        if (drive_update) begin
            state_next.applied_speed = drive_limited;
        end

        speed = state_next.applied_speed;
        result.dir_out      = speed > 9'sd0;
        result.dir_in       = speed < 9'sd0;
        result.pwm_duty     = speed[8] ? 8'(-speed) : speed[7:0];
        result.drive_speed  = speed;
        result.auto_mode    = !state_next.manual_mode;
        result.target_raw   = state_next.target_pos;
        result.position_raw = state_next.current_pos;
    end

endmodule

// File: hdl/tilt_actuator_p_control_core.sv
// Top level of the tilt actuator proportional position controller.
// Holds the configuration, input, state and output registers around
// tapc_step; depends on tapc_pkg.
//
//   Channel   Direction  Handshake           Payload
//   s_        in         s_tvalid/s_tready   s_tuser command, s_tdata fields
//   m_        out        m_tvalid/m_tready   m_tdata result fields
//   cfg_      in         cfg_wr_en only      cfg_index, cfg_data
//
// One transaction is accepted per cycle while s_tready is high; its result
// passes through the input register, then the result register, and appears
// on m_ once the result register is loaded after a single pass through
// tapc_step. The controller state is updated in the same edge that loads the
// result register, so the next command sees it.
// Reset (aresetn low, synchronous) restores the register defaults, manual
// mode, no target and a stopped motor. A stall on m_ holds the result and,
// once the input register is full as well, drops s_tready.
module tilt_actuator_p_control_core
    import tapc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [9:0] pot_sample, [16:10] target_percent, [26:17] joystick, rest zero
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // [1:0] command
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] dir_out, [1] dir_in, [9:2] pwm_duty, [18:10] drive_speed,
    // [19] auto_mode, [30:20] target_raw, [40:31] position_raw, rest zero
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    tapc_cfg_t    cfg_reg;
    tapc_cfg_t    cfg_next;
    tapc_state_t  state_reg;
    tapc_state_t  state_next;
    tapc_item_t   item_reg;
    tapc_item_t   item_in;
    logic         in_valid_reg;
    logic         in_valid_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    tapc_result_t result;
    logic         advance;
    logic         s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign item_in.command        = tapc_cmd_t'(s_tuser);
    assign item_in.pot_sample     = s_tdata[9:0];
    assign item_in.target_percent = s_tdata[16:10];
    assign item_in.joystick       = $signed(s_tdata[26:17]);

    tapc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (tapc_reg_idx_t'(cfg_index))
                REG_MIN_DRIVE:      cfg_next.min_drive         = cfg_data[7:0];
                REG_MAX_DRIVE:      cfg_next.max_drive         = cfg_data[7:0];
                REG_DEADBAND:       cfg_next.deadband          = cfg_data;
                REG_GAIN_Q4:        cfg_next.gain_q4           = cfg_data;
                REG_POT_LOW_LIMIT:  cfg_next.pot_low_limit     = cfg_data;
                REG_POT_HIGH_LIMIT: cfg_next.pot_high_limit    = cfg_data;
                REG_JOY_DEADZONE:   cfg_next.joystick_deadzone = cfg_data[7:0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_drive         <= RST_MIN_DRIVE;
            cfg_reg.max_drive         <= RST_MAX_DRIVE;
            cfg_reg.deadband          <= RST_DEADBAND;
            cfg_reg.gain_q4           <= RST_GAIN_Q4;
            cfg_reg.pot_low_limit     <= RST_POT_LOW_LIMIT;
            cfg_reg.pot_high_limit    <= RST_POT_HIGH_LIMIT;
            cfg_reg.joystick_deadzone <= RST_JOY_DEADZONE;
            state_reg.manual_mode     <= 1'b1;
            state_reg.target_pos      <= TARGET_NONE;
            state_reg.current_pos     <= 10'd0;
            state_reg.applied_speed   <= 9'sd0;
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_in;
        end
        if (advance) begin
            out_data_reg <= {7'b0, result.position_raw, result.target_raw, result.auto_mode,
                             result.drive_speed, result.pwm_duty, result.dir_in,
                             result.dir_out};
        end
    end

    // Automatic mode is only ever entered together with a valid target.
    a_auto_has_target: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.manual_mode |-> (state_reg.target_pos != TARGET_NONE))
        else $error("automatic mode without a target");

    // The input side is held off only while both registers are occupied.
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("s_tready low without a full pipeline");

    // A command that leaves the input register shows its result next cycle.
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result missing after a command advanced");

    // A manual command always leaves the controller in manual mode.
    a_manual_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item_reg.command == CMD_MANUAL) |=> state_reg.manual_mode)
        else $error("manual command did not select manual mode");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for tilt_actuator_p_control_core: position-loop
// ticks, target and joystick commands under many register settings, checked
// against a cycle-free model of the controller. Depends on tapc_pkg.
`timescale 1ns / 100ps

module testbench;
    import tapc_pkg::*;

    // The spare command code; the block leaves the controller state as it is.
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int N_PHASES = 8;
    localparam int N_REGS = 7;
    localparam int ITEMS_PER_PHASE = 166;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    // Tracks the controller state, predicts one result per command and
    // compares the results that leave the block in order.
    class drive_tracker;
        int min_drv, max_drv, dband, gain, lo_lim, hi_lim, jdz;
        bit manual;
        int target, cur_pos, speed;
        tapc_result_t pending_results[$];
        int n_errors, n_checked, n_commands;

        function new();
            min_drv = RST_MIN_DRIVE;
            max_drv = RST_MAX_DRIVE;
            dband = RST_DEADBAND;
            gain = RST_GAIN_Q4;
            lo_lim = RST_POT_LOW_LIMIT;
            hi_lim = RST_POT_HIGH_LIMIT;
            jdz = RST_JOY_DEADZONE;
            manual = 1'b1;
            target = -1;
            cur_pos = 0;
            speed = 0;
        endfunction

        function int clip(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void set_reg(tapc_reg_idx_t idx, int val);
            case (idx)
                REG_MIN_DRIVE:      min_drv = val & 8'hFF;
                REG_MAX_DRIVE:      max_drv = val & 8'hFF;
                REG_DEADBAND:       dband = val & 10'h3FF;
                REG_GAIN_Q4:        gain = val & 10'h3FF;
                REG_POT_LOW_LIMIT:  lo_lim = val & 10'h3FF;
                REG_POT_HIGH_LIMIT: hi_lim = val & 10'h3FF;
                REG_JOY_DEADZONE:   jdz = val & 8'hFF;
                default: ;
            endcase
        endfunction

        // Soft limits cancel drive that points further past a limit.
        function void apply_drive(int drv);
            if (cur_pos >= hi_lim && drv > 0) drv = 0;
            if (cur_pos <= lo_lim && drv < 0) drv = 0;
            speed = drv;
        endfunction

        function void note_command(logic [1:0] cmd, logic [9:0] sample, logic [6:0] pct,
                                   logic [9:0] joy_bits);
            int joy, err, mag, drv, p;
            tapc_result_t res;
            joy = $signed(joy_bits);
            case (cmd)
                CMD_TICK: begin
                    cur_pos = sample;
                    if (!manual && target != -1) begin
                        err = target - cur_pos;
                        mag = (err < 0) ? -err : err;
                        if (mag > dband) begin
                            drv = (err * gain) / 16;
                            if (drv > 0) drv = clip(drv, min_drv, max_drv);
                            else drv = clip(drv, -max_drv, -min_drv);
                            apply_drive(drv);
                        end else begin
                            apply_drive(0);
                        end
                    end
                end
                CMD_SET_TARGET: begin
                    p = clip(pct, PCT_LOW, PCT_HIGH);
                    manual = 1'b0;
                    target = (p * (hi_lim - lo_lim)) / 100 + lo_lim;
                end
                CMD_MANUAL: begin
                    drv = clip((joy * max_drv) / 256, -max_drv, max_drv);
                    mag = (drv < 0) ? -drv : drv;
                    if (mag < jdz) drv = 0;
                    manual = 1'b1;
                    cur_pos = sample;
                    apply_drive(drv);
                end
                default: ;
            endcase
            res.dir_out = speed > 0;
            res.dir_in = speed < 0;
            res.pwm_duty = 8'((speed < 0) ? -speed : speed);
            res.drive_speed = 9'(speed);
            res.auto_mode = !manual;
            res.target_raw = 11'(target);
            res.position_raw = 10'(cur_pos);
            pending_results.push_back(res);
            n_commands++;
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            tapc_result_t got, want;
            got.dir_out = data[0];
            got.dir_in = data[1];
            got.pwm_duty = data[9:2];
            got.drive_speed = data[18:10];
            got.auto_mode = data[19];
            got.target_raw = data[30:20];
            got.position_raw = data[40:31];
            n_checked++;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: result with no command outstanding, tdata=%h", data);
                return;
            end
            want = pending_results.pop_front();
            if (got.dir_out !== want.dir_out || got.dir_in !== want.dir_in ||
                got.pwm_duty !== want.pwm_duty || got.drive_speed !== want.drive_speed ||
                got.auto_mode !== want.auto_mode || got.target_raw !== want.target_raw ||
                got.position_raw !== want.position_raw) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("ERROR: expected out=%b in=%b pwm=%0d speed=%0d auto=%b tgt=%0d pos=%0d",
                             want.dir_out, want.dir_in, want.pwm_duty, want.drive_speed,
                             want.auto_mode, want.target_raw, want.position_raw);
                    $display("       actual   out=%b in=%b pwm=%0d speed=%0d auto=%b tgt=%0d pos=%0d",
                             got.dir_out, got.dir_in, got.pwm_duty, got.drive_speed,
                             got.auto_mode, got.target_raw, got.position_raw);
                end
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    drive_tracker tracker = new();

    tilt_actuator_p_control_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Both handshakes are sampled with the values they held at the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready === 1'b1)
                tracker.note_command(s_tuser, s_tdata[9:0], s_tdata[16:10], s_tdata[26:17]);
            if (m_tvalid === 1'b1 && m_tready)
                tracker.check_result(m_tdata);
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random back-pressure whose density follows snk_idle_pct.
    initial begin
        forever begin
            @(posedge aclk);
            if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send(logic [1:0] cmd, int sample, int pct, int joy);
        logic [S_TDATA_W-1:0] word;
        int gap;
        word = '0;
        word[9:0] = 10'(sample);
        word[16:10] = 7'(pct);
        word[26:17] = 10'(joy);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= word;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Holds off the sender until every outstanding result has been taken.
    // The first edge lets the monitor note the last accepted transaction.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(int vals[N_REGS]);
        for (int i = 0; i < N_REGS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data <= CFG_DATA_W'(vals[i]);
            tracker.set_reg(tapc_reg_idx_t'(i), vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly target-seeking sequences: ticks land mostly near the active target or
    // the soft limits, with target, manual and spare commands and junk fields mixed in.
    task automatic send_random();
        int r, sample, pct, joy;
        logic [1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 8) cmd = CMD_SET_TARGET;
        else if (r < 22) cmd = CMD_MANUAL;
        else if (r < 25) cmd = CMD_SPARE;
        else cmd = CMD_TICK;
        r = $urandom_range(0, 99);
        if (r < 50 && tracker.target >= 0)
            sample = tracker.target + $urandom_range(0, 160) - 80;
        else if (r < 65)
            sample = (r < 58 ? tracker.lo_lim : tracker.hi_lim) + $urandom_range(0, 6) - 3;
        else
            sample = $urandom_range(0, 1023);
        if (sample < 0) sample = 0;
        if (sample > 1023) sample = 1023;
        pct = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 100) : $urandom_range(0, 127);
        joy = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 512) - 256
                                           : $urandom_range(0, 1023);
        send(cmd, sample, pct, joy);
    endtask

    int cfg_plan [N_PHASES][N_REGS] = '{
        '{60, 250, 10, 96, 215, 550, 40},
        '{0, 0, 0, 0, 0, 0, 0},
        '{255, 255, 0, 1023, 0, 1023, 255},
        '{255, 255, 1023, 1023, 1023, 1023, 255},
        '{30, 200, 5, 300, 800, 100, 20},
        '{200, 100, 3, 50, 100, 900, 10},
        '{0, 255, 0, 1023, 0, 1023, 0},
        '{0, 0, 0, 0, 0, 0, 0}
    };
    int reg_max [N_REGS] = '{255, 255, 1023, 1023, 1023, 1023, 255};

    initial begin
        int vals[N_REGS];
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: no-target ticks, joystick extremes, deadzone,
        // soft limits, target clamping and the spare command.
        send(CMD_TICK, 300, 0, 0);
        send(CMD_SPARE, 1023, 127, 1023);
        send(CMD_MANUAL, 400, 0, 256);
        send(CMD_MANUAL, 400, 0, -256);
        send(CMD_MANUAL, 300, 0, 511);
        send(CMD_MANUAL, 300, 0, -512);
        send(CMD_MANUAL, 300, 0, 30);
        send(CMD_MANUAL, 550, 0, 200);
        send(CMD_MANUAL, 215, 0, -200);
        send(CMD_TICK, 100, 0, 0);
        send(CMD_SET_TARGET, 1023, 0, 511);
        send(CMD_TICK, 0, 0, 0);
        send(CMD_TICK, 1023, 0, 0);
        send(CMD_TICK, 295, 0, 0);
        send(CMD_TICK, 280, 0, 0);
        send(CMD_TICK, 287, 0, 0);
        send(CMD_SET_TARGET, 0, 127, -512);
        send(CMD_TICK, 600, 0, 0);
        send(CMD_SET_TARGET, 0, 25, 0);
        send(CMD_SET_TARGET, 0, 69, 0);
        send(CMD_SET_TARGET, 0, 100, 0);
        send(CMD_TICK, 200, 0, 0);
        send(CMD_SPARE, 0, 0, 0);
        send(CMD_TICK, 446, 0, 0);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            for (int i = 0; i < N_REGS; i++)
                vals[i] = (p == N_PHASES - 1) ? $urandom_range(0, reg_max[i]) : cfg_plan[p][i];
            program_regs(vals);
            case (p % 3)
                0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
                1: begin src_idle_pct = 20; snk_idle_pct = 25; end
                default: begin src_idle_pct = 45; snk_idle_pct = 60; end
            endcase
            repeat (ITEMS_PER_PHASE) send_random();
            drain();
        end

        repeat (8) @(posedge aclk);
        $display("Ran %0d commands over %0d register settings with random stalls on both sides;",
                 tracker.n_commands, N_PHASES + 1);
        $display("%0d results checked, %0d mismatches.", tracker.n_checked, tracker.n_errors);
        if (tracker.n_errors == 0 && tracker.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding", tracker.pending());
        $display("Test completed with failures");
        $finish;
    end

endmodule
